// ===== sv/rencd_pkg.sv =====
package rencd_pkg;

    localparam int TICKS_W   = 8;
    localparam int CLICK_W   = 4;
    localparam int STEP_W    = 8;
    localparam int IN_BYTES  = 1;
    localparam int OUT_BYTES = 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [TICKS_W-1:0] DEBOUNCE_TICKS_RST = 8'd8;
    localparam logic [CLICK_W-1:0] CLICK_STEPS_RST    = 4'd4;
    localparam logic signed [STEP_W:0] STEP_MAX = 9'sd127;
    localparam logic signed [STEP_W:0] STEP_MIN = -9'sd127;

    typedef logic signed [STEP_W-1:0] step_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE_TICKS = 1'b0,
        CFG_CLICK_STEPS    = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic accept;
        logic level_next;
    } deb_status_t;

    // one quadrature step, saturating at +/-127
    function automatic step_t step_move(input step_t step, input logic up);
        logic signed [STEP_W:0] sum;
        sum = {step[STEP_W-1], step} + (up ? 9'sd1 : -9'sd1);
        if (sum > STEP_MAX)
        begin
            sum = STEP_MAX;
        end
        else if (sum < STEP_MIN)
        begin
            sum = STEP_MIN;
        end
        return sum[STEP_W-1:0];
    endfunction

endpackage

// ===== sv/rencd_debounce.sv =====
module rencd_debounce (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               sample,
    input  logic [rencd_pkg::TICKS_W-1:0]      ticks,
    output logic                               level,
    output rencd_pkg::deb_status_t             status
);

    logic                           level_reg;
    logic                           pend_reg;
    logic                           pend_next;
    logic [rencd_pkg::TICKS_W-1:0]  wait_reg;
    logic [rencd_pkg::TICKS_W-1:0]  wait_next;
    logic                           accept;

    always_comb
    begin
        pend_next = pend_reg;
        wait_next = wait_reg;
        accept    = 1'b0;
        if (sample == level_reg)
        begin
            pend_next = 1'b0;
            wait_next = '0;
        end
        else if (!pend_reg)
        begin
            pend_next = 1'b1;
            wait_next = ticks;
        end
        else if (wait_reg <= rencd_pkg::TICKS_W'(1))
        begin
            pend_next = 1'b0;
            wait_next = '0;
            accept    = 1'b1;
        end
        else
        begin
            wait_next = wait_reg - rencd_pkg::TICKS_W'(1);
        end
    end

    assign status.accept     = accept;
    assign status.level_next = level_reg ^ accept;
    assign level             = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= 1'b1;
            pend_reg  <= 1'b0;
            wait_reg  <= '0;
        end
        else if (advance)
        begin
            level_reg <= level_reg ^ accept;
            pend_reg  <= pend_next;
            wait_reg  <= wait_next;
        end
    end

endmodule

// ===== sv/rotary_encoder_click_decoder_top.sv =====
// Rotary encoder click decoder: per-line debounce, quadrature step count, click on rest.
// A transaction crosses the input register, then the output register, to its result.
// One transaction per cycle unless m_axis_tready stalls; state update is combinational.
// Reset (rst_n, async, active low): lines idle high, no wait pending, step count 0,
// debounce_ticks = 8, click_steps = 4, both pipeline stages empty.
module rotary_encoder_click_decoder_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [8*rencd_pkg::IN_BYTES-1:0]        s_axis_tdata,  // line_a, line_b
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // click_valid, click_clockwise, filtered_a, filtered_b
    output logic [8*rencd_pkg::OUT_BYTES-1:0]       m_axis_tdata,
    input  logic                                    cfg_we,
    input  logic [rencd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [rencd_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [rencd_pkg::TICKS_W-1:0] debounce_ticks_reg;
    logic [rencd_pkg::CLICK_W-1:0] click_steps_reg;

    logic in_valid_reg;
    logic in_a_reg;
    logic in_b_reg;

    logic out_valid_reg;
    logic click_valid_reg;
    logic click_cw_reg;
    logic filt_a_reg;
    logic filt_b_reg;

    rencd_pkg::step_t step_reg;
    rencd_pkg::step_t step_next;
    logic             click_next;
    logic             cw_next;

    logic out_ready;
    logic advance;

    logic                    level_a;
    logic                    level_b;
    rencd_pkg::deb_status_t  status_a;
    rencd_pkg::deb_status_t  status_b;

    logic signed [rencd_pkg::STEP_W:0] th;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_ready;
    assign s_axis_tready = !in_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= rencd_pkg::DEBOUNCE_TICKS_RST;
            click_steps_reg    <= rencd_pkg::CLICK_STEPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rencd_pkg::CFG_DEBOUNCE_TICKS:
                    debounce_ticks_reg <= cfg_data[rencd_pkg::TICKS_W-1:0];
                rencd_pkg::CFG_CLICK_STEPS:
                    click_steps_reg <= cfg_data[rencd_pkg::CLICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_a_reg <= s_axis_tdata[0];
            in_b_reg <= s_axis_tdata[1];
        end
    end

    rencd_debounce u_deb_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_a_reg),
        .ticks   (debounce_ticks_reg),
        .level   (level_a),
        .status  (status_a)
    );

    rencd_debounce u_deb_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_b_reg),
        .ticks   (debounce_ticks_reg),
        .level   (level_b),
        .status  (status_b)
    );

    assign th = {{(rencd_pkg::STEP_W + 1 - rencd_pkg::CLICK_W){1'b0}}, click_steps_reg};

    // line A first, then line B against the updated A level
    always_comb
    begin
        step_next  = step_reg;
        click_next = 1'b0;
        cw_next    = 1'b0;
        if (status_a.accept)
        begin
            step_next = rencd_pkg::step_move(step_next, status_a.level_next != level_b);
            if (status_a.level_next && level_b)
            begin
                if ($signed({step_next[rencd_pkg::STEP_W-1], step_next}) >= th)
                begin
                    click_next = 1'b1;
                    cw_next    = 1'b1;
                end
                else if ($signed({step_next[rencd_pkg::STEP_W-1], step_next}) <= -th)
                begin
                    click_next = 1'b1;
                    cw_next    = 1'b0;
                end
                step_next = '0;
            end
        end
        if (status_b.accept)
        begin
            step_next = rencd_pkg::step_move(step_next,
                                             status_b.level_next == status_a.level_next);
            if (status_a.level_next && status_b.level_next)
            begin
                if ($signed({step_next[rencd_pkg::STEP_W-1], step_next}) >= th)
                begin
                    click_next = 1'b1;
                    cw_next    = 1'b1;
                end
                else if ($signed({step_next[rencd_pkg::STEP_W-1], step_next}) <= -th)
                begin
                    click_next = 1'b1;
                    cw_next    = 1'b0;
                end
                step_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                step_reg <= step_next;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            click_valid_reg <= click_next;
            click_cw_reg    <= cw_next;
            filt_a_reg      <= status_a.level_next;
            filt_b_reg      <= status_b.level_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8*rencd_pkg::OUT_BYTES - 4){1'b0}},
                            filt_b_reg, filt_a_reg, click_cw_reg, click_valid_reg};

endmodule
